/* design/sbc_pkg.sv */
// Shared types and constants for the serial byte capture block.
// No dependencies; imported by the receiver and the top level.
`default_nettype none

package sbc_pkg;

	// Receiver phases, one half-bit tick per step
	typedef enum logic [1:0] {
		RX_IDLE  = 2'd0,
		RX_START = 2'd1,
		RX_DATA  = 2'd2,
		RX_TAIL  = 2'd3
	} rx_phase_t;

	// Input action codes
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SLOT_W   = 6;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned THRESH_W = 7;
	localparam int unsigned HBC_W    = 5;

	localparam logic [BYTE_W-1:0]   PREAMBLE        = 8'h55;
	localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 7'd10;
	localparam logic [HBC_W-1:0]    DATA_TICKS      = 5'd16;
	localparam logic [HBC_W-1:0]    TAIL_LAST       = 5'd1;

	// Byte handed from the receiver to the capture logic
	typedef struct packed {
		logic              done;
		logic [BYTE_W-1:0] data;
	} rx_byte_t;

endpackage

`default_nettype wire

/* design/sbc_in_if.sv */
// Input channel: one line sample or clear action per transfer.
// Depends on nothing; used by serial_byte_capture_on_preamble.
`default_nettype none

interface sbc_in_if;
	logic valid;
	logic ready;
	logic action;
	logic line_level;

	modport source (output valid, output action, output line_level, input ready);
	modport sink (input valid, input action, input line_level, output ready);
endinterface

`default_nettype wire

/* design/sbc_out_if.sv */
// Output channel: one captured byte with its slot and count per transfer.
// Depends on nothing; used by serial_byte_capture_on_preamble.
`default_nettype none

interface sbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic [5:0] slot;
	logic [6:0] count_after;

	modport source (output valid, output byte_value, output slot, output count_after,
		input ready);
	modport sink (input valid, input byte_value, input slot, input count_after,
		output ready);
endinterface

`default_nettype wire

/* design/serial_byte_capture_on_preamble.sv */
// Top level of the serial byte capture block: receiver, capture count, result register.
// Depends on sbc_pkg, sbc_in_if, sbc_out_if and sbc_rx.
`default_nettype none

// Takes one item per clock while input ready is high: each transfer is one half-bit
// line sample or a clear. Every item is handled in the cycle it is accepted; a
// captured byte appears on the output register the next cycle, and throughput is one
// item per cycle while the output is drained. Input ready drops only while a
// result sits unread. Bytes are captured after a 0x55 preamble, up to CAPACITY
// of them; a 0x55 arriving with more than restart_threshold bytes stored starts
// the capture over. slot and count_after are the low 6 and 7 bits of pos and pos + 1.
module serial_byte_capture_on_preamble
	import sbc_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	sbc_in_if.sink                   din,
	sbc_out_if.source                dout,
	input  wire logic                cfg_we,
	input  wire logic [THRESH_W-1:0] cfg_wdata
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned EW = (CW > COUNT_W) ? CW : COUNT_W;

	logic [THRESH_W-1:0] thresh_q;
	logic                capture_q;
	logic [CW-1:0]       count_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic                accept;
	logic                tick;
	rx_byte_t            rx_byte;
	logic                is_pre;
	logic                cap_d;
	logic [CW-1:0]       pos;
	logic [CW-1:0]       count_d;
	logic                emit;
	logic [EW-1:0]       pos_ext;
	logic [EW-1:0]       cnt_ext;

	assign din.ready = !out_valid_q || dout.ready;
	assign accept    = din.valid && din.ready;
	assign tick      = accept && (din.action == ACT_SAMPLE);

	sbc_rx u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.line_level (din.line_level),
		.rx_byte    (rx_byte)
	);

	// Decide capture for a finished byte
	always_comb begin
		is_pre  = rx_byte.done && (rx_byte.data == PREAMBLE);
		cap_d   = capture_q || is_pre;
		pos     = count_q;
		if (is_pre && (EW'(count_q) > EW'(thresh_q))) pos = '0;
		emit    = rx_byte.done && cap_d && (pos < CW'(CAPACITY));
		count_d = emit ? pos + CW'(1) : pos;
		pos_ext = EW'(pos);
		cnt_ext = EW'(pos) + EW'(1);
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thresh_q <= THRESHOLD_RESET;
		else if (cfg_we) thresh_q <= cfg_wdata;
	end

	// Capture flag and count: clear action or finished byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_q <= 1'b0;
			count_q   <= '0;
		end else if (accept && din.action == ACT_CLEAR) begin
			capture_q <= 1'b0;
			count_q   <= '0;
		end else if (rx_byte.done) begin
			capture_q <= cap_d;
			count_q   <= count_d;
		end
	end

	// Result register: load on emit, drop after its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (emit) out_valid_q <= 1'b1;
		else if (dout.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= rx_byte.data;
			out_slot_q  <= pos_ext[SLOT_W-1:0];
			out_count_q <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.byte_value  = out_byte_q;
	assign dout.slot        = out_slot_q;
	assign dout.count_after = out_count_q;

endmodule

`default_nettype wire

/* design/sbc_rx.sv */
// 8N1 deserializer driven by half-bit ticks; flags the byte on its last tick.
// Depends on sbc_pkg.
`default_nettype none

module sbc_rx
	import sbc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     tick,
	input  wire logic     line_level,
	output rx_byte_t      rx_byte
);

	rx_phase_t           phase_q, phase_d;
	logic [HBC_W-1:0]    hbc_q, hbc_d;
	logic [BYTE_W-1:0]   shift_q, shift_d;
	logic                prev_q;
	logic [HBC_W-1:0]    hbc_inc;

	// Hold receiver state, advance on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RX_IDLE;
			hbc_q   <= '0;
			shift_q <= '0;
			prev_q  <= 1'b1;
		end else if (tick) begin
			phase_q <= phase_d;
			hbc_q   <= hbc_d;
			shift_q <= shift_d;
			prev_q  <= line_level;
		end
	end

	assign hbc_inc = hbc_q + HBC_W'(1);

	// Next phase, counter, shift register and byte strobe
	always_comb begin
		phase_d      = phase_q;
		hbc_d        = hbc_q;
		shift_d      = shift_q;
		rx_byte.done = 1'b0;
		rx_byte.data = shift_q;
		unique case (phase_q)
			RX_IDLE: begin
				if (prev_q && !line_level) phase_d = RX_START;
			end
			RX_START: begin
				if (!line_level) begin
					phase_d = RX_DATA;
					hbc_d   = '0;
					shift_d = '0;
				end else begin
					phase_d = RX_IDLE;
				end
			end
			RX_DATA: begin
				hbc_d = hbc_inc;
				// sample on every second tick, LSB first
				if (!hbc_inc[0]) shift_d = {line_level, shift_q[BYTE_W-1:1]};
				if (hbc_inc >= DATA_TICKS) begin
					phase_d = RX_TAIL;
					hbc_d   = '0;
				end
			end
			RX_TAIL: begin
				hbc_d = hbc_inc;
				if (hbc_q >= TAIL_LAST) begin
					rx_byte.done = tick;
					phase_d      = RX_IDLE;
					hbc_d        = '0;
				end
			end
			default: phase_d = RX_IDLE;
		endcase
	end

endmodule

`default_nettype wire

/* design/sbc_checker.sv */
// Port-level checks for serial_byte_capture_on_preamble, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none

module sbc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic [5:0] out_slot,
	input wire logic [6:0] out_count
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_slot)
			&& $stable(out_count))
		else $error("stalled result changed");

	// Count always one past the slot written
	a_count_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_count[5:0] == out_slot + 6'd1))
		else $error("count_after does not follow slot");

	// Input stalls only behind an unread result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty result register");

	// No result without an input transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
		else $error("result appeared without an input transfer");

endmodule

bind serial_byte_capture_on_preamble sbc_checker u_sbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_byte  (dout.byte_value),
	.out_slot  (dout.slot),
	.out_count (dout.count_after)
);

`default_nettype wire
